>>> rtl/set_assoc_lru_tag_store_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU tag store
// Shared property wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_TAG_STORE_ASSERT_SVH
`define SET_ASSOC_LRU_TAG_STORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SALTS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SALTS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/salts_pkg.sv
// ----------------------------------------------------------------------------
// salts_pkg
// Shared constants for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package salts_pkg;

    localparam int DEF_CACHE_BYTES = 16384;
    localparam int DEF_WAYS        = 4;
    localparam int DEF_LINE_BYTES  = 64;

    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int WAY_USED_W  = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = 1 + WAY_USED_W + 2 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

>>> rtl/set_assoc_lru_tag_store.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Takes one read address per word and returns one result word: hit flag, way
// hit or filled, and saturating hit and miss totals. Sustains one address per
// cycle while m_tready stays high: the set row is read from a single
// synchronous RAM in the accept cycle, then compared, aged and written back in
// the next unless the result word is stalled; a row written back is bypassed
// to a following access of the same set. After reset a clearing pass writes
// every set row, one per cycle, over CACHE_BYTES / (WAYS * LINE_BYTES) sets
// rounded down to a power of two (64 by default); s_tready stays low meanwhile.
`timescale 1ns / 1ps

`include "set_assoc_lru_tag_store_assert.svh"

module set_assoc_lru_tag_store
    import salts_pkg::*;
#(
    parameter int CACHE_BYTES = DEF_CACHE_BYTES,
    parameter int WAYS        = DEF_WAYS,
    parameter int LINE_BYTES  = DEF_LINE_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] address
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] hit, [2:1] way_used,
                                              // [34:3] hit_count, [66:35] miss_count
);

    localparam int SETS_RAW = (CACHE_BYTES / (WAYS * LINE_BYTES) == 0) ?
                              1 : CACHE_BYTES / (WAYS * LINE_BYTES);
    localparam int IDX_W    = $clog2(SETS_RAW + 1) - 1;
    localparam int SETS     = 1 << IDX_W;
    localparam int OFF_W    = $clog2(LINE_BYTES + 1) - 1;
    localparam int TAG_W    = ADDR_W - OFF_W - IDX_W;
    localparam int SET_AW   = (IDX_W > 0) ? IDX_W : 1;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W    = RANK_W;
    localparam int ROW_W    = WAYS * (1 + RANK_W + TAG_W);

    logic [ROW_W-1:0]  mem [SETS];

    logic [ROW_W-1:0]  rd_row_reg;
    logic [ROW_W-1:0]  byp_row_reg;
    logic              byp_sel_reg, byp_sel_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [SET_AW-1:0] s1_set_reg;
    logic [TAG_W-1:0]  s1_tag_reg;
    logic              clr_reg, clr_next;
    logic [SET_AW-1:0] clr_idx_reg, clr_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_hit_reg;
    logic [WAY_USED_W-1:0] m_way_reg;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]  miss_cnt_reg, miss_cnt_next;

    logic              s_accept;
    logic              s1_adv;
    logic [SET_AW-1:0] in_set;
    logic [TAG_W-1:0]  in_tag;
    logic [ROW_W-1:0]  cur_row;
    logic [ROW_W-1:0]  new_row;
    logic              upd_hit;
    logic [WAY_W-1:0]  upd_way;
    logic              hit_sat, miss_sat;
    logic [CNT_W:0]    cnt_sum;

    assign in_set = SET_AW'((s_tdata[ADDR_W-1:0] >> OFF_W) & ADDR_W'(SETS - 1));
    assign in_tag = TAG_W'(s_tdata[ADDR_W-1:0] >> (OFF_W + IDX_W));

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_reg && (!s1_valid_reg || s1_adv);
    assign s_accept = s_tvalid && s_tready;
    assign cur_row  = byp_sel_reg ? byp_row_reg : rd_row_reg;

    salts_row_update #(
        .WAYS   (WAYS),
        .RANK_W (RANK_W),
        .TAG_W  (TAG_W),
        .WAY_W  (WAY_W)
    ) u_row_update (
        .row_valid (cur_row[WAYS-1:0]),
        .row_rank  (cur_row[WAYS +: WAYS*RANK_W]),
        .row_tag   (cur_row[WAYS*(1+RANK_W) +: WAYS*TAG_W]),
        .tag       (s1_tag_reg),
        .new_valid (new_row[WAYS-1:0]),
        .new_rank  (new_row[WAYS +: WAYS*RANK_W]),
        .new_tag   (new_row[WAYS*(1+RANK_W) +: WAYS*TAG_W]),
        .hit       (upd_hit),
        .way       (upd_way)
    );

    // set row RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (s1_adv) begin
            mem[s1_set_reg] <= new_row;
        end
        if (s_accept) begin
            rd_row_reg <= mem[in_set];
        end
    end

    assign hit_sat  = &hit_cnt_reg;
    assign miss_sat = &miss_cnt_reg;
    assign cnt_sum  = (CNT_W + 1)'(hit_cnt_reg) + (CNT_W + 1)'(miss_cnt_reg);

    always_comb begin
        clr_next      = clr_reg;
        clr_idx_next  = clr_idx_reg;
        s1_valid_next = s1_valid_reg;
        byp_sel_next  = byp_sel_reg;
        m_valid_next  = m_valid_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;

        if (clr_reg) begin
            clr_idx_next = clr_idx_reg + SET_AW'(1);
            if (clr_idx_reg == SET_AW'(SETS - 1)) begin
                clr_next = 1'b0;
            end
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (s1_adv) begin
            s1_valid_next = 1'b0;
            m_valid_next  = 1'b1;
            if (upd_hit) begin
                hit_cnt_next = hit_sat ? hit_cnt_reg : hit_cnt_reg + CNT_W'(1);
            end else begin
                miss_cnt_next = miss_sat ? miss_cnt_reg : miss_cnt_reg + CNT_W'(1);
            end
        end

        if (s_accept) begin
            s1_valid_next = 1'b1;
            // forward the row written at this edge when the same set is read
            byp_sel_next  = s1_adv && (in_set == s1_set_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_idx_reg  <= '0;
            s1_valid_reg <= 1'b0;
            byp_sel_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            clr_reg      <= clr_next;
            clr_idx_reg  <= clr_idx_next;
            s1_valid_reg <= s1_valid_next;
            byp_sel_reg  <= byp_sel_next;
            m_valid_reg  <= m_valid_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_set_reg  <= in_set;
            s1_tag_reg  <= in_tag;
            byp_row_reg <= new_row;
        end
        if (s1_adv) begin
            m_hit_reg <= upd_hit;
            m_way_reg <= WAY_USED_W'(upd_way);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), miss_cnt_reg, hit_cnt_reg,
                       m_way_reg, m_hit_reg};

    `SALTS_ASSERT_NEXT(a_clear_once, aclk, aresetn, !clr_reg, !clr_reg, "clearing pass restarted")
    `SALTS_ASSERT_NEXT(a_count_step, aclk, aresetn, s1_adv && !hit_sat && !miss_sat, cnt_sum == $past(cnt_sum) + (CNT_W + 1)'(1), "hit and miss totals did not advance by one")
    `SALTS_ASSERT_NEXT(a_result_load, aclk, aresetn, s1_adv, m_valid_reg, "finished access gave no result word")
    `SALTS_ASSERT(a_no_accept_in_clear, aclk, aresetn, !(clr_reg && s1_adv), "access completed during clearing pass")

endmodule

>>> rtl/salts_row_update.sv
// ----------------------------------------------------------------------------
// salts_row_update
// Tag compare, victim choice and LRU rank aging for one set row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salts_row_update #(
    parameter int WAYS   = 4,
    parameter int RANK_W = 2,
    parameter int TAG_W  = 20,
    parameter int WAY_W  = 2
) (
    input  logic [WAYS-1:0]        row_valid,
    input  logic [WAYS*RANK_W-1:0] row_rank,
    input  logic [WAYS*TAG_W-1:0]  row_tag,
    input  logic [TAG_W-1:0]       tag,
    output logic [WAYS-1:0]        new_valid,
    output logic [WAYS*RANK_W-1:0] new_rank,
    output logic [WAYS*TAG_W-1:0]  new_tag,
    output logic                   hit,
    output logic [WAY_W-1:0]       way
);

    logic [RANK_W-1:0] rank_arr [WAYS];
    logic [TAG_W-1:0]  tag_arr  [WAYS];
    logic [WAYS-1:0]   hit_vec;
    logic [WAYS-1:0]   lru_vec;
    logic              any_inv;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  inv_way;
    logic [WAY_W-1:0]  lru_way;
    logic [RANK_W:0]   old_rank;

    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            rank_arr[k] = row_rank[k*RANK_W +: RANK_W];
            tag_arr[k]  = row_tag[k*TAG_W +: TAG_W];
            hit_vec[k]  = row_valid[k] && (tag_arr[k] == tag);
            lru_vec[k]  = (rank_arr[k] == RANK_W'(WAYS - 1));
        end
        any_inv = ~&row_valid;
        hit     = |hit_vec;
    end

    // lowest-numbered match wins
    always_comb begin
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                hit_way = WAY_W'(k);
            end
            if (!row_valid[k]) begin
                inv_way = WAY_W'(k);
            end
            if (lru_vec[k]) begin
                lru_way = WAY_W'(k);
            end
        end
    end

    always_comb begin
        if (hit) begin
            way = hit_way;
        end else if (any_inv) begin
            way = inv_way;
        end else begin
            way = lru_way;
        end

        if (!hit && any_inv) begin
            old_rank = (RANK_W + 1)'(WAYS);
        end else begin
            old_rank = {1'b0, rank_arr[way]};
        end

        for (int k = 0; k < WAYS; k++) begin
            new_valid[k]                  = row_valid[k];
            new_tag[k*TAG_W +: TAG_W]     = tag_arr[k];
            new_rank[k*RANK_W +: RANK_W]  = rank_arr[k];
            if (WAY_W'(k) == way) begin
                new_valid[k]                 = 1'b1;
                new_tag[k*TAG_W +: TAG_W]    = tag;
                new_rank[k*RANK_W +: RANK_W] = '0;
            end else if (row_valid[k] && ({1'b0, rank_arr[k]} < old_rank)) begin
                new_rank[k*RANK_W +: RANK_W] = rank_arr[k] + RANK_W'(1);
            end
        end
    end

endmodule
